// File: hdl/sha_pkg.sv
// Shared types, constants and functions for the streaming SHA-256 hasher.
// Depends on nothing; every other file imports it.
`default_nettype none
package sha_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned QueueDepthDef = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Operation carried from the front part to the compression engine.
	typedef enum logic [1:0] {
		OP_BLOCK  = 2'd0,
		OP_DIGEST = 2'd1
	} blk_op_t;

	typedef struct packed {
		blk_op_t        op;
		logic [511:0]   block;
	} blk_cmd_t;

	typedef enum logic [2:0] {
		FS_ACCEPT = 3'd0,
		FS_PAD1   = 3'd1,
		FS_PAD2   = 3'd2
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE  = 2'd0,
		BS_ROUND = 2'd1,
		BS_ADD   = 2'd2,
		BS_EMIT  = 2'd3
	} back_state_t;

	localparam logic [255:0] HashInit = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

// File: hdl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: front part, command queue, engine.
// Depends on sha_pkg, sha_front, sha_queue and sha_engine.
`default_nettype none
// Bytes are taken one per cycle while the queue has room, with a pause after
// each 64th byte while the full block moves into the queue; each full 64-byte
// block costs the engine a load, 64 rounds and an add, so once the block queue
// (four deep by default) fills, the input waits on the engine. The item marked
// last queues one or two padding blocks, holding the input off while each one
// is queued, and eight digest words follow, most significant first, after the
// last compression.
module sha256_stream_hasher #(
	parameter int unsigned QueueDepth = sha_pkg::QueueDepthDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::in_item_t  in_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output sha_pkg::out_item_t      out_data,
	output logic                    out_valid,
	input  wire logic               out_ready
);
	import sha_pkg::*;

	blk_cmd_t f_cmd, q_cmd;
	logic     f_valid, f_ready, q_valid, q_ready;

	sha_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	sha_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n,
		.wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	sha_engine u_engine (
		.clk, .arst_n,
		.cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.out_data, .out_valid, .out_ready
	);
endmodule
`default_nettype wire

// File: hdl/sha_front.sv
// Front part: gathers bytes into 64-byte blocks, counts the message length and
// builds the padding blocks. Depends on sha_pkg.
`default_nettype none
module sha_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sha_pkg::in_item_t in_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output sha_pkg::blk_cmd_t     cmd,
	output logic                  cmd_valid,
	input  wire logic             cmd_ready
);
	import sha_pkg::*;

	logic [511:0] blk_q;       // byte 0 of the block in the top eight bits
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic         pad_q;       // 0x80 already placed in the first padding block
	logic         full_q;      // a full block waits in blk_q for the queue
	front_state_t state_q, state_d;
	logic [511:0] pad_blk;
	logic         in_fire, full_now;
	logic [6:0]   fill_next;

	assign in_fire = in_valid && in_ready;

	// Padding block built from the held bytes.
	always_comb begin
		pad_blk = blk_q;
		for (int i = 0; i < BlockBytes; i++) begin
			if (6'(i) == fill_q && !pad_q) pad_blk[511 - 8*i -: 8] = 8'h80;
			else if (6'(i) > fill_q || (pad_q && 6'(i) >= fill_q))
				pad_blk[511 - 8*i -: 8] = 8'h00;
		end
		if (state_q == FS_PAD2) pad_blk[63:0] = bits_q;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd_valid = 1'b0;
		cmd.op    = OP_BLOCK;
		cmd.block = blk_q;
		full_now  = 1'b0;
		fill_next = {1'b0, fill_q};
		case (state_q)
			FS_ACCEPT: begin
				// A full block is held back until the queue takes it.
				in_ready = 1'b1;
			end
			FS_PAD1: begin
				// When the last byte filled the block, that block goes out unpadded.
				cmd_valid = 1'b1;
				cmd.block = (fill_q == 6'd0) ? blk_q : pad_blk;
				if (cmd_ready) state_d = FS_PAD2;
			end
			FS_PAD2: begin
				cmd_valid = 1'b1;
				cmd.op    = OP_DIGEST;
				cmd.block = pad_blk;
				if (cmd_ready) state_d = FS_ACCEPT;
			end
			default: state_d = FS_ACCEPT;
		endcase
		if (state_q == FS_ACCEPT && fill_q == 6'd0 && full_q) begin
			in_ready  = 1'b0;
			cmd_valid = 1'b1;
		end
		if (in_fire) begin
			if (in_data.byte_valid) begin
				fill_next = {1'b0, fill_q} + 7'd1;
				full_now  = fill_next[6];
			end
			if (in_data.last_byte) begin
				// Second block needed when fewer than nine bytes remain.
				state_d = (fill_next[6] || fill_next[5:0] > 6'd55) ? FS_PAD1 : FS_PAD2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_ACCEPT;
			fill_q  <= '0;
			bits_q  <= '0;
			pad_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == FS_ACCEPT && full_q && cmd_ready) full_q <= 1'b0;
			if (in_fire) begin
				fill_q <= fill_next[5:0];
				if (in_data.byte_valid) bits_q <= bits_q + 64'd8;
				if (full_now && !in_data.last_byte) full_q <= 1'b1;
				if (full_now && in_data.last_byte) pad_q <= 1'b0;
			end
			if (state_q == FS_PAD1 && cmd_ready) begin
				pad_q  <= fill_q != 6'd0;
				fill_q <= '0;
			end
			if (state_q == FS_PAD2 && cmd_ready) begin
				pad_q  <= 1'b0;
				fill_q <= '0;
				bits_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_data.byte_valid)
			blk_q[8*(63 - int'(fill_q)) +: 8] <= in_data.data_byte;
	end
endmodule
`default_nettype wire

// File: hdl/sha_queue.sv
// Short queue of block commands between the front part and the engine.
// Depends on sha_pkg.
`default_nettype none
module sha_queue #(
	parameter int unsigned Depth = sha_pkg::QueueDepthDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::blk_cmd_t wr_data,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	output sha_pkg::blk_cmd_t      rd_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready
);
	import sha_pkg::*;

	localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

	blk_cmd_t        mem_q [Depth];
	logic [Aw-1:0]   wp_q, rp_q;
	logic [Aw:0]     cnt_q;
	logic            wr_fire, rd_fire;

	assign wr_ready = cnt_q != (Aw+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr_fire  = wr_valid && wr_ready;
	assign rd_fire  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_fire) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd_fire) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(wr_fire) - (Aw+1)'(rd_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) mem_q[wp_q] <= wr_data;
	end
endmodule
`default_nettype wire

// File: hdl/sha_engine.sv
// Back part: one SHA-256 round per cycle over a rolling 16-word schedule, then
// digest output through a registered result stage. Depends on sha_pkg.
`default_nettype none
module sha_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::blk_cmd_t cmd,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	output sha_pkg::out_item_t     out_data,
	output logic                   out_valid,
	input  wire logic              out_ready
);
	import sha_pkg::*;

	back_state_t  state_q, state_d;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   t_q;
	logic [2:0]   idx_q;
	logic         dig_q;
	logic [31:0]  w_new, s0, s1, t1, t2, a, e;

	assign a = v_q[0];
	assign e = v_q[4];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = s1 + w_q[9] + s0 + w_q[0];
	assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(t_q) + w_q[0];
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		case (state_q)
			BS_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) state_d = BS_ROUND;
			end
			BS_ROUND: if (t_q == 6'd63) state_d = BS_ADD;
			BS_ADD:   state_d = dig_q ? BS_EMIT : BS_IDLE;
			BS_EMIT:  if (out_ready && idx_q == 3'd7) state_d = BS_IDLE;
			default:  state_d = BS_IDLE;
		endcase
	end

	assign out_valid            = state_q == BS_EMIT;
	assign out_data.digest_word = h_q[idx_q];
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = idx_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			t_q     <= '0;
			idx_q   <= '0;
			dig_q   <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= HashInit[255 - 32*i -: 32];
		end else begin
			state_q <= state_d;
			case (state_q)
				BS_IDLE: begin
					t_q <= '0;
					if (cmd_valid) dig_q <= cmd.op == OP_DIGEST;
				end
				BS_ROUND: t_q <= t_q + 6'd1;
				BS_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					idx_q <= '0;
				end
				BS_EMIT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7)
						for (int i = 0; i < 8; i++) h_q[i] <= HashInit[255 - 32*i -: 32];
				end
				default: ;
			endcase
		end
	end

	// Working variables and the schedule window; w_q[0] is this round's word.
	always_ff @(posedge clk) begin
		if (state_q == BS_IDLE && cmd_valid) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= cmd.block[511 - 32*i -: 32];
		end else if (state_q == BS_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end
endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the streaming SHA-256 hasher.
// Depends on sha_pkg and sha256_stream_hasher; predicts digests with its own SHA-256.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sha_pkg::*;

	localparam int unsigned WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_item_t in_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	out_item_t out_data;
	logic out_valid;
	logic out_ready = 1'b0;

	sha256_stream_hasher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
		.out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: running hash, partial block and bit count.
	logic [31:0] hash_acc [8];
	logic [7:0]  blk_bytes [64];
	int unsigned blk_fill;
	logic [63:0] msg_bits;

	const logic [31:0] k_tab [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	in_item_t   pending_bytes [$];
	out_item_t  expected_words [$];
	int unsigned errors = 0;
	bit quiet = 1'b0;

	function automatic logic [31:0] ror(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void restart_digest();
		hash_acc = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		blk_fill = 0;
		msg_bits = '0;
	endfunction

	function automatic void compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = hash_acc;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
	endfunction

	function automatic void absorb_item(in_item_t it);
		out_item_t o;
		if (it.byte_valid) begin
			blk_bytes[blk_fill] = it.data_byte;
			msg_bits += 64'd8;
			blk_fill++;
			if (blk_fill == 64) begin
				compress();
				blk_fill = 0;
			end
		end
		if (!it.last_byte) return;
		blk_bytes[blk_fill] = 8'h80;
		blk_fill++;
		if (blk_fill > 56) begin
			for (int i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
			compress();
			blk_fill = 0;
		end
		for (int i = blk_fill; i < 56; i++) blk_bytes[i] = 8'h00;
		for (int i = 0; i < 8; i++) blk_bytes[63-i] = msg_bits[8*i +: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = hash_acc[i];
			o.word_index = 3'(i);
			o.last_word = (i == 7);
			expected_words.push_back(o);
		end
		restart_digest();
	endfunction

	function automatic void push_message(int unsigned len, bit end_with_byte);
		in_item_t it;
		for (int unsigned i = 0; i < len; i++) begin
			it.data_byte = 8'($urandom);
			it.byte_valid = 1'b1;
			it.last_byte = end_with_byte && (i == len - 1);
			pending_bytes.push_back(it);
		end
		if (!end_with_byte || len == 0) begin
			it.data_byte = 8'($urandom);
			it.byte_valid = 1'b0;
			it.last_byte = 1'b1;
			pending_bytes.push_back(it);
		end
	endfunction

	// Driver: presents queued items, with random bursts of idle cycles.
	int unsigned in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				absorb_item(in_data);
				void'(pending_bytes.pop_front());
			end
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if ((in_valid && in_ready ? pending_bytes.size() > 0
						: pending_bytes.size() > 0)) begin
					if (!quiet && $urandom_range(0, 15) == 0) begin
						in_gap <= $urandom_range(1, 19) - 1;
						in_valid <= 1'b0;
					end else begin
						in_data <= pending_bytes[0];
						in_valid <= 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each digest word transaction and stalls the output.
	int unsigned out_gap = 0;
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected digest word %h", out_data.digest_word);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (out_data.digest_word !== e.digest_word) begin
						$error("digest_word expected %h actual %h", e.digest_word,
							out_data.digest_word);
						errors++;
					end
					if (out_data.word_index !== e.word_index) begin
						$error("word_index expected %0d actual %0d", e.word_index,
							out_data.word_index);
						errors++;
					end
					if (out_data.last_word !== e.last_word) begin
						$error("last_word expected %0d actual %0d", e.last_word,
							out_data.last_word);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				out_gap <= $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		in_item_t it;
		restart_digest();
		for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
		// Directed: empty message, lone byte, ignored byte, padding edges.
		push_message(0, 1'b0);
		it = '{data_byte: 8'hff, byte_valid: 1'b0, last_byte: 1'b0};
		pending_bytes.push_back(it);
		it = '{data_byte: 8'h00, byte_valid: 1'b1, last_byte: 1'b1};
		pending_bytes.push_back(it);
		it = '{data_byte: 8'hff, byte_valid: 1'b1, last_byte: 1'b1};
		pending_bytes.push_back(it);
		push_message(2, 1'b0);
		push_message(55, 1'b1);
		push_message(56, 1'b1);
		push_message(64, 1'b0);
		push_message(63, 1'b1);
		push_message(64, 1'b1);
		// Random messages, mostly short, sometimes spanning several blocks,
		// with ignored items sprinkled between messages.
		for (int n = 0; n < 6; n++) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 140)
				: $urandom_range(0, 20);
			if ($urandom_range(0, 3) == 0) begin
				it.data_byte = 8'($urandom);
				it.byte_valid = 1'b0;
				it.last_byte = 1'b0;
				pending_bytes.push_back(it);
			end
			push_message(len, $urandom_range(0, 1));
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_bytes.size() < 40);
		quiet = 1'b1;
		wait (pending_bytes.size() == 0 && !in_valid);
		wait (expected_words.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
